>>> rtl/mrt_pkg.sv
package mrt_pkg;

    // Payload field widths, fixed by the item format
    localparam int OPERATION_W = 2;
    localparam int CHANNEL_W   = 3;
    localparam int DURATION_W  = 24;
    localparam int BITMAP_W    = 8;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF      = 8;
    localparam int DURATION_BITS_DEF = 24;

    // Operation codes; the fourth code is reserved and changes nothing
    typedef enum logic [OPERATION_W-1:0] {
        OP_TICK         = 2'd0,
        OP_SWITCH       = 2'd1,
        OP_SET_DURATION = 2'd2
    } t_op;

    // Per-channel commands for one item, already gated by the stage advance
    typedef struct packed {
        logic tick;
        logic switch_on;
        logic switch_off;
        logic set_duration;
    } t_lane_ctl;

    // Per-channel state after the item
    typedef struct packed {
        logic relay;
        logic timing;
        logic expired;
    } t_lane_stat;

endpackage

>>> rtl/mrt_if.sv
interface mrt_cmd_if import mrt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OPERATION_W-1:0] operation;
    logic [CHANNEL_W-1:0]   channel;
    logic                   turn_on;
    logic [DURATION_W-1:0]  duration_seconds;

    modport source (output valid, operation, channel, turn_on, duration_seconds,
                    input ready);
    modport sink   (input valid, operation, channel, turn_on, duration_seconds,
                    output ready);
endinterface

interface mrt_res_if import mrt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [BITMAP_W-1:0]   relay_outputs;
    logic                  any_relay_on;
    logic                  channel_on;
    logic [DURATION_W-1:0] channel_remaining;
    logic [BITMAP_W-1:0]   expired_mask;
    logic [BITMAP_W-1:0]   timing_mask;

    modport source (output valid, relay_outputs, any_relay_on, channel_on,
                    channel_remaining, expired_mask, timing_mask,
                    input ready);
    modport sink   (input valid, relay_outputs, any_relay_on, channel_on,
                    channel_remaining, expired_mask, timing_mask,
                    output ready);
endinterface

>>> rtl/mrt_chan.sv
module mrt_chan import mrt_pkg::*; #(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic [DURATION_BITS-1:0] i_duration,
    output t_lane_stat               o_stat,
    output logic [DURATION_BITS-1:0] o_remaining
);

    localparam logic [DURATION_BITS-1:0] EL_MAX = {DURATION_BITS{1'b1}};

    logic                     r_relay,    n_relay;
    logic                     r_timing,   n_timing;
    logic [DURATION_BITS-1:0] r_duration, n_duration;
    logic [DURATION_BITS-1:0] r_elapsed,  n_elapsed;
    logic [DURATION_BITS-1:0] elapsed_inc;
    logic                     expired;

    // Saturating one-second advance
    assign elapsed_inc = (r_elapsed == EL_MAX) ? r_elapsed
                                               : r_elapsed + DURATION_BITS'(1);

    // Next state of this channel
    always_comb begin
        n_relay    = r_relay;
        n_timing   = r_timing;
        n_duration = r_duration;
        n_elapsed  = r_elapsed;
        expired    = 1'b0;
        if (i_ctl.tick && r_timing) begin
            n_elapsed = elapsed_inc;
            if (elapsed_inc >= r_duration) begin
                expired  = 1'b1;
                n_timing = 1'b0;
                n_relay  = 1'b0;
            end
        end
        if (i_ctl.switch_on) begin
            n_relay = 1'b1;
            if (r_duration != '0) begin
                n_elapsed = '0;
                n_timing  = 1'b1;
            end
        end
        if (i_ctl.switch_off) begin
            n_relay  = 1'b0;
            n_timing = 1'b0;
        end
        if (i_ctl.set_duration) begin
            n_duration = i_duration;
        end
    end

    // Hold channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay    <= 1'b0;
            r_timing   <= 1'b0;
            r_duration <= '0;
            r_elapsed  <= '0;
        end else begin
            r_relay    <= n_relay;
            r_timing   <= n_timing;
            r_duration <= n_duration;
            r_elapsed  <= n_elapsed;
        end
    end

    // Report state after the item; remaining time is zero unless timing
    assign o_stat.relay   = n_relay;
    assign o_stat.timing  = n_timing;
    assign o_stat.expired = expired;
    assign o_remaining    = (n_timing && n_duration > n_elapsed) ? n_duration - n_elapsed
                                                                 : '0;

endmodule

>>> rtl/multi_relay_auto_off_timer.sv
// Channel  Dir  Handshake      Payload
// i_cmd    in   valid / ready  operation, channel, turn_on, duration_seconds
// o_res    out  valid / ready  relay_outputs, any_relay_on, channel_on,
//                              channel_remaining, expired_mask, timing_mask
//
// One item per cycle while o_res is not stalled; a result shows on o_res after its item is taken,
// when the input register passes it to the result register.
// All channels update in parallel in the cycle their item leaves the input register.
// Synchronous active-low reset clears relays, durations, elapsed counts and timers.
// A stalled result holds the input register; i_cmd.ready drops only when both are full.
module multi_relay_auto_off_timer import mrt_pkg::*; #(
    parameter int CHANNELS      = CHANNELS_DEF,
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mrt_cmd_if.sink   i_cmd,
    mrt_res_if.source o_res
);

    // Input register
    logic                   r_in_valid;
    logic [OPERATION_W-1:0] r_op;
    logic [CHANNEL_W-1:0]   r_ch;
    logic                   r_on;
    logic [DURATION_W-1:0]  r_dur;

    // Result register
    logic                  r_out_valid;
    logic [BITMAP_W-1:0]   r_relay_outputs,     n_relay_outputs;
    logic                  r_any_relay_on,      n_any_relay_on;
    logic                  r_channel_on,        n_channel_on;
    logic [DURATION_W-1:0] r_channel_remaining, n_channel_remaining;
    logic [BITMAP_W-1:0]   r_expired_mask,      n_expired_mask;
    logic [BITMAP_W-1:0]   r_timing_mask,       n_timing_mask;

    logic out_free;
    logic fire;
    logic in_accept;
    logic tick_fire;
    logic switch_fire;
    logic set_fire;

    logic [CHANNELS-1:0]      sel_vec;
    logic [CHANNELS-1:0]      relay_vec;
    logic [CHANNELS-1:0]      timing_vec;
    logic [CHANNELS-1:0]      expired_vec;
    logic [DURATION_BITS-1:0] rem_sel;
    logic [DURATION_BITS-1:0] dur_lane;

    t_lane_ctl                lane_ctl  [CHANNELS];
    t_lane_stat               lane_stat [CHANNELS];
    logic [DURATION_BITS-1:0] lane_rem  [CHANNELS];

    // Handshake and stage advance
    assign out_free    = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && out_free;
    assign i_cmd.ready = !r_in_valid || out_free;
    assign in_accept   = i_cmd.valid && i_cmd.ready;

    // Decode the operation
    always_comb begin
        tick_fire   = 1'b0;
        switch_fire = 1'b0;
        set_fire    = 1'b0;
        case (r_op)
            OP_TICK:         tick_fire   = fire;
            OP_SWITCH:       switch_fire = fire;
            OP_SET_DURATION: set_fire    = fire;
            default:         ;
        endcase
    end

    // Select the addressed channel; channels beyond the count never match
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            sel_vec[k] = (32'(r_ch) == k);
        end
    end

    assign dur_lane = DURATION_BITS'(r_dur);

    // Channel lanes
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        assign lane_ctl[g] = '{
            tick:         tick_fire,
            switch_on:    switch_fire && sel_vec[g] && r_on,
            switch_off:   switch_fire && sel_vec[g] && !r_on,
            set_duration: set_fire && sel_vec[g]
        };

        mrt_chan #(
            .DURATION_BITS (DURATION_BITS)
        ) u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl[g]),
            .i_duration  (dur_lane),
            .o_stat      (lane_stat[g]),
            .o_remaining (lane_rem[g])
        );
    end

    // Gather bitmaps and pick the addressed channel
    always_comb begin
        rem_sel = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            relay_vec[k]   = lane_stat[k].relay;
            timing_vec[k]  = lane_stat[k].timing;
            expired_vec[k] = lane_stat[k].expired;
            if (sel_vec[k]) begin
                rem_sel = rem_sel | lane_rem[k];
            end
        end
    end

    assign n_relay_outputs     = BITMAP_W'(relay_vec);
    assign n_any_relay_on      = |relay_vec;
    assign n_channel_on        = |(relay_vec & sel_vec);
    assign n_channel_remaining = DURATION_W'(rem_sel);
    assign n_expired_mask      = BITMAP_W'(expired_vec);
    assign n_timing_mask       = BITMAP_W'(timing_vec);

    // Load the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_cmd.operation;
            r_ch  <= i_cmd.channel;
            r_on  <= i_cmd.turn_on;
            r_dur <= i_cmd.duration_seconds;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_relay_outputs     <= n_relay_outputs;
            r_any_relay_on      <= n_any_relay_on;
            r_channel_on        <= n_channel_on;
            r_channel_remaining <= n_channel_remaining;
            r_expired_mask      <= n_expired_mask;
            r_timing_mask       <= n_timing_mask;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.relay_outputs     = r_relay_outputs;
    assign o_res.any_relay_on      = r_any_relay_on;
    assign o_res.channel_on        = r_channel_on;
    assign o_res.channel_remaining = r_channel_remaining;
    assign o_res.expired_mask      = r_expired_mask;
    assign o_res.timing_mask       = r_timing_mask;

endmodule

>>> rtl/mrt_checker.sv
module mrt_checker import mrt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  i_ready,
    input logic [BITMAP_W-1:0]   i_relay_outputs,
    input logic                  i_any_relay_on,
    input logic                  i_channel_on,
    input logic [DURATION_W-1:0] i_channel_remaining,
    input logic [BITMAP_W-1:0]   i_expired_mask,
    input logic [BITMAP_W-1:0]   i_timing_mask
);

    // A relay shown on implies the summary flag
    a_any_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_relay_outputs != '0) |-> i_any_relay_on)
        else $error("any_relay_on low while a relay is on");

    // An expired channel has been switched off
    a_expired_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_expired_mask & i_relay_outputs) == '0))
        else $error("expired channel still on");

    // A timing channel always has its relay on
    a_timing_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((i_timing_mask & ~i_relay_outputs) == '0))
        else $error("timing channel with relay off");

    // Time left only on a channel that is on
    a_remaining_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_channel_remaining != '0) |-> i_channel_on)
        else $error("remaining time on a channel that is off");

    // A stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_relay_outputs)
                                   && $stable(i_channel_remaining)
                                   && $stable(i_timing_mask)))
        else $error("result changed while stalled");

endmodule

bind multi_relay_auto_off_timer mrt_checker u_mrt_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (o_res.valid),
    .i_ready             (o_res.ready),
    .i_relay_outputs     (o_res.relay_outputs),
    .i_any_relay_on      (o_res.any_relay_on),
    .i_channel_on        (o_res.channel_on),
    .i_channel_remaining (o_res.channel_remaining),
    .i_expired_mask      (o_res.expired_mask),
    .i_timing_mask       (o_res.timing_mask)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mrt_pkg::*;

    localparam int          NCH          = CHANNELS_DEF;
    localparam int          RANDOM_ITEMS = 900;
    localparam int          QUIET_ITEMS  = 150;
    localparam int          HOLD_AT_ITEM = 400;
    localparam int          LONG_HOLD    = 60;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_PRINTS   = 50;
    localparam logic [1:0]  OP_RESERVED  = 2'd3;
    localparam logic [23:0] DUR_TOP      = 24'hFFFFFF;

    // One input item and one result item, at the port widths
    typedef struct packed {
        logic [OPERATION_W-1:0] op;
        logic [CHANNEL_W-1:0]   ch;
        logic                   on;
        logic [DURATION_W-1:0]  dur;
    } t_relay_cmd;

    typedef struct packed {
        logic [BITMAP_W-1:0]   relays;
        logic                  any_on;
        logic                  ch_on;
        logic [DURATION_W-1:0] remaining;
        logic [BITMAP_W-1:0]   expired;
        logic [BITMAP_W-1:0]   timing;
    } t_relay_status;

    typedef struct {
        t_relay_cmd    cmd;
        bit            typed;
        t_relay_status want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrt_cmd_if cmd_if ();
    mrt_res_if res_if ();

    multi_relay_auto_off_timer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always #10 i_clk = ~i_clk;

    // Predicted relay state
    logic [NCH-1:0]        pred_relays;
    logic [NCH-1:0]        pred_timing;
    logic [DURATION_W-1:0] pred_dur     [NCH];
    logic [DURATION_W-1:0] pred_elapsed [NCH];

    t_relay_status expected_status [$];
    t_directed_row directed_rows [$];
    int            mismatches   = 0;
    int            cmds_sent    = 0;
    bit            gap_on       = 1'b1;
    bit            quiet_tail   = 1'b0;
    bit            hold_request = 1'b0;
    bit            hold_done    = 1'b0;

    // Apply one item to the predicted state and return the status it reports
    function automatic t_relay_status advance_relays(input t_relay_cmd c);
        t_relay_status s;
        int            i;
        s = '0;
        case (c.op)
            OP_TICK: begin
                for (i = 0; i < NCH; i++) begin
                    if (pred_timing[i]) begin
                        if (pred_elapsed[i] != DUR_TOP)
                            pred_elapsed[i] = pred_elapsed[i] + 24'd1;
                        if (pred_elapsed[i] >= pred_dur[i]) begin
                            pred_timing[i] = 1'b0;
                            pred_relays[i] = 1'b0;
                            s.expired[i]   = 1'b1;
                        end
                    end
                end
            end
            OP_SWITCH: begin
                if (c.on) begin
                    pred_relays[c.ch] = 1'b1;
                    if (pred_dur[c.ch] != '0) begin
                        pred_elapsed[c.ch] = '0;
                        pred_timing[c.ch]  = 1'b1;
                    end
                end else begin
                    pred_relays[c.ch] = 1'b0;
                    pred_timing[c.ch] = 1'b0;
                end
            end
            OP_SET_DURATION: pred_dur[c.ch] = c.dur;
            default: ;
        endcase
        s.relays = pred_relays;
        s.any_on = |pred_relays;
        s.ch_on  = pred_relays[c.ch];
        s.timing = pred_timing;
        if (pred_timing[c.ch] && pred_dur[c.ch] > pred_elapsed[c.ch])
            s.remaining = pred_dur[c.ch] - pred_elapsed[c.ch];
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic add_row(input logic [1:0] op, input logic [2:0] ch, input logic on,
                           input logic [23:0] dur, input bit typed,
                           input t_relay_status want);
        t_directed_row r;
        r.cmd   = '{op: op, ch: ch, on: on, dur: dur};
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    // Build a random item, weighted toward short durations so timers expire
    function automatic t_relay_cmd random_cmd();
        t_relay_cmd c;
        int         k;
        int         m;
        k    = $urandom_range(0, 99);
        m    = $urandom_range(0, 9);
        c.ch = CHANNEL_W'($urandom_range(0, NCH - 1));
        c.on = ($urandom_range(0, 99) < 70);
        if (m == 0)
            c.dur = '0;
        else if (m == 1)
            c.dur = DURATION_W'($urandom);
        else if (m == 2)
            c.dur = DUR_TOP;
        else
            c.dur = DURATION_W'($urandom_range(1, 8));
        if (k < 38)
            c.op = OP_TICK;
        else if (k < 70)
            c.op = OP_SWITCH;
        else if (k < 95)
            c.op = OP_SET_DURATION;
        else
            c.op = OP_RESERVED;
        return c;
    endfunction

    // Offer one item, wait for it to be taken, then queue its expected status
    task automatic offer_cmd(input t_relay_cmd c, input bit typed,
                             input t_relay_status want);
        t_relay_status predicted;
        if (gap_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        cmd_if.valid            <= 1'b1;
        cmd_if.operation        <= c.op;
        cmd_if.channel          <= c.ch;
        cmd_if.turn_on          <= c.on;
        cmd_if.duration_seconds <= c.dur;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predicted = advance_relays(c);
        expected_status.push_back(typed ? want : predicted);
        cmds_sent++;
    endtask

    // Stimulus: reset, directed table, random items, then drain
    initial begin
        i_rst_n                 <= 1'b0;
        cmd_if.valid            <= 1'b0;
        cmd_if.operation        <= '0;
        cmd_if.channel          <= '0;
        cmd_if.turn_on          <= 1'b0;
        cmd_if.duration_seconds <= '0;
        pred_relays = '0;
        pred_timing = '0;
        for (int i = 0; i < NCH; i++) begin
            pred_dur[i]     = '0;
            pred_elapsed[i] = '0;
        end

        // Opening rows have their status typed in; the rest use the predictor
        add_row(OP_TICK,         3'd0, 1'b0, 24'd0,   1'b1, '0);
        add_row(OP_RESERVED,     3'd7, 1'b1, DUR_TOP, 1'b1, '0);
        add_row(OP_SET_DURATION, 3'd0, 1'b0, DUR_TOP, 1'b1, '0);
        add_row(OP_SWITCH,       3'd0, 1'b1, 24'd0,   1'b1,
                {8'h01, 1'b1, 1'b1, 24'hFFFFFF, 8'h00, 8'h01});
        add_row(OP_SET_DURATION, 3'd7, 1'b0, 24'd1,   1'b1,
                {8'h01, 1'b1, 1'b0, 24'h000000, 8'h00, 8'h01});
        add_row(OP_SWITCH,       3'd7, 1'b1, 24'd0,   1'b1,
                {8'h81, 1'b1, 1'b1, 24'h000001, 8'h00, 8'h81});
        add_row(OP_TICK,         3'd7, 1'b0, 24'd0,   1'b1,
                {8'h01, 1'b1, 1'b0, 24'h000000, 8'h80, 8'h01});
        // latch on with no timeout
        add_row(OP_SWITCH,       3'd3, 1'b1, 24'd0,   1'b0, '0);
        add_row(OP_TICK,         3'd3, 1'b0, 24'd0,   1'b0, '0);
        // shrink the duration below the elapsed count mid-run
        add_row(OP_SET_DURATION, 3'd5, 1'b0, 24'd3,   1'b0, '0);
        add_row(OP_SWITCH,       3'd5, 1'b1, 24'd0,   1'b0, '0);
        add_row(OP_TICK,         3'd5, 1'b0, 24'd0,   1'b0, '0);
        add_row(OP_SET_DURATION, 3'd5, 1'b0, 24'd0,   1'b0, '0);
        add_row(OP_TICK,         3'd5, 1'b0, 24'd0,   1'b0, '0);
        // restart a running timer
        add_row(OP_SET_DURATION, 3'd2, 1'b0, 24'd2,   1'b0, '0);
        add_row(OP_SWITCH,       3'd2, 1'b1, 24'd0,   1'b0, '0);
        add_row(OP_TICK,         3'd2, 1'b0, 24'd0,   1'b0, '0);
        add_row(OP_SWITCH,       3'd2, 1'b1, 24'd0,   1'b0, '0);
        add_row(OP_TICK,         3'd2, 1'b0, 24'd0,   1'b0, '0);
        // switch on with zero duration while still timing
        add_row(OP_SET_DURATION, 3'd4, 1'b0, 24'd5,   1'b0, '0);
        add_row(OP_SWITCH,       3'd4, 1'b1, 24'd0,   1'b0, '0);
        add_row(OP_SET_DURATION, 3'd4, 1'b0, 24'd0,   1'b0, '0);
        add_row(OP_SWITCH,       3'd4, 1'b1, 24'd0,   1'b0, '0);
        add_row(OP_TICK,         3'd4, 1'b0, 24'd0,   1'b0, '0);
        // switch off a timing and a latched relay
        add_row(OP_SWITCH,       3'd0, 1'b0, 24'd0,   1'b0, '0);
        add_row(OP_SWITCH,       3'd3, 1'b0, 24'd0,   1'b0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            offer_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                gap_on = ($urandom_range(0, 2) != 0);
            if (cmds_sent >= HOLD_AT_ITEM)
                hold_request = 1'b1;
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            offer_cmd(random_cmd(), 1'b0, '0);
        end
        cmd_if.valid <= 1'b0;

        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Drive result ready: random stalls, one long hold-off, none in the tail
    initial begin
        res_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!quiet_tail && hold_request && !hold_done) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Check each result against the oldest expected status
    always @(posedge i_clk) begin
        t_relay_status want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected result, relays", 32'(res_if.relay_outputs), 0);
            end else begin
                want = expected_status.pop_front();
                if (res_if.relay_outputs !== want.relays)
                    report_mismatch("relay_outputs", 32'(res_if.relay_outputs),
                                    32'(want.relays));
                if (res_if.any_relay_on !== want.any_on)
                    report_mismatch("any_relay_on", 32'(res_if.any_relay_on),
                                    32'(want.any_on));
                if (res_if.channel_on !== want.ch_on)
                    report_mismatch("channel_on", 32'(res_if.channel_on), 32'(want.ch_on));
                if (res_if.channel_remaining !== want.remaining)
                    report_mismatch("channel_remaining", 32'(res_if.channel_remaining),
                                    32'(want.remaining));
                if (res_if.expired_mask !== want.expired)
                    report_mismatch("expired_mask", 32'(res_if.expired_mask),
                                    32'(want.expired));
                if (res_if.timing_mask !== want.timing)
                    report_mismatch("timing_mask", 32'(res_if.timing_mask),
                                    32'(want.timing));
            end
        end
    end

    // Count cycles with no item moving on either side
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
